// ===== design/bhpq_pkg.sv =====
// Shared types, sizes and helper functions for the binary heap priority queue.
// Used by the RAM-backed level cells, the top level and the port checker.
// No dependencies.
package bhpq_pkg;

  // Heap capacity and element width
  localparam int unsigned DEPTH  = 1024;
  localparam int unsigned DATA_W = 32;

  // Element count width; the heap has one level per count bit
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned NLVL  = CNT_W;
  localparam int unsigned LVL_W = $clog2(NLVL);
  // Slot position within one level
  localparam int unsigned POS_W = NLVL - 1;
  // Global index width, wide enough for child indices of the bottom level
  localparam int unsigned IDX_W = CNT_W + 2;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_REMOVE = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Per-level cell sequencer
  typedef enum logic [1:0] {
    C_IDLE,
    C_DN_WAIT,
    C_UP_WAIT
  } cell_state_e;

  // Top-level controller
  typedef enum logic [2:0] {
    S_IDLE,
    S_LAST_REQ,
    S_LAST_RD,
    S_SIFT,
    S_TOP_REQ,
    S_TOP_RD,
    S_DONE
  } ctl_state_e;

  typedef struct packed {
    logic  req_type;
    data_t value;
  } in_word_t;

  typedef struct packed {
    status_e          status;
    data_t            removed_value;
    data_t            top_value;
    logic             top_valid;
    logic [CNT_W-1:0] count;
  } out_word_t;

  // Carried element: the hole sits at pos in the receiving level
  typedef struct packed {
    logic             valid;
    logic [POS_W-1:0] pos;
    data_t            value;
  } tok_t;

  // Neighbor read request
  typedef struct packed {
    logic             valid;
    logic [POS_W-1:0] pos;
  } rdreq_t;

  // Controller read of one slot
  typedef struct packed {
    logic             valid;
    logic [LVL_W-1:0] level;
    logic [POS_W-1:0] pos;
  } fetch_t;

  // Level memory port
  typedef struct packed {
    logic             we;
    logic [POS_W-1:0] waddr;
    data_t            wdata;
    logic [POS_W-1:0] raddr_a;
    logic [POS_W-1:0] raddr_b;
  } ram_req_t;

  // True when b must sit above a
  function automatic logic outranks(data_t a, data_t b, logic min_mode);
    return min_mode ? (a > b) : (a < b);
  endfunction

  // Level of the slot whose one-based index is j (position of the leading one)
  function automatic logic [LVL_W-1:0] idx_level(logic [CNT_W-1:0] j);
    logic [LVL_W-1:0] lvl;
    lvl = '0;
    for (int b = 0; b < int'(CNT_W); b++) begin
      if (j[b]) lvl = LVL_W'(b);
    end
    return lvl;
  endfunction

endpackage

// ===== design/bhpq_ram.sv =====
// Simple dual-read, single-write RAM with registered read data.
// Holds the slots of one heap level. No dependencies.
module bhpq_ram #(
  parameter int unsigned AddrW = 1,
  parameter int unsigned DataW = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_a_i,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [DataW-1:0] rdata_a_o,
  output logic [DataW-1:0] rdata_b_o
);

  logic [DataW-1:0] mem [2**AddrW];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Two registered read ports
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

// ===== design/bhpq_cell.sv =====
// One heap level: drives its level memory, serves neighbor reads, and moves
// the carried element one level up or down per step. Depends on bhpq_pkg.
module bhpq_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [bhpq_pkg::LVL_W-1:0] lvl_i,
  input  logic                     min_mode_i,
  input  logic [bhpq_pkg::CNT_W-1:0] count_i,
  input  bhpq_pkg::fetch_t         fetch_i,
  input  bhpq_pkg::tok_t           tok_dn_i,
  input  bhpq_pkg::tok_t           tok_up_i,
  output bhpq_pkg::tok_t           tok_dn_o,
  output bhpq_pkg::tok_t           tok_up_o,
  input  bhpq_pkg::rdreq_t         dn_req_i,
  input  bhpq_pkg::rdreq_t         up_req_i,
  output bhpq_pkg::rdreq_t         dn_req_o,
  output bhpq_pkg::rdreq_t         up_req_o,
  input  bhpq_pkg::data_t          child_rd_a_i,
  input  bhpq_pkg::data_t          child_rd_b_i,
  input  bhpq_pkg::data_t          parent_rd_a_i,
  output bhpq_pkg::ram_req_t       ram_o,
  output logic                     done_o
);
  import bhpq_pkg::*;

  cell_state_e      state_q, state_d;
  logic [POS_W-1:0] pos_q, pos_d;
  data_t            val_q, val_d;
  tok_t             tok_dn_q, tok_dn_d;
  tok_t             tok_up_q, tok_up_d;

  logic [IDX_W-1:0] child_base;
  logic [IDX_W-1:0] li_in;
  logic [IDX_W-1:0] li_q;
  logic [IDX_W-1:0] ri_q;
  logic             take_l, take_r;
  data_t            best_v;

  // Global index of the left child of a slot in this level
  assign child_base = (IDX_W'(2) << lvl_i) - IDX_W'(1);
  assign li_in      = child_base + IDX_W'({tok_dn_i.pos, 1'b0});
  assign li_q       = child_base + IDX_W'({pos_q, 1'b0});
  assign ri_q       = li_q + IDX_W'(1);

  // Child selection: left wins a tie with right
  assign take_l = outranks(val_q, child_rd_a_i, min_mode_i);
  assign best_v = take_l ? child_rd_a_i : val_q;
  assign take_r = (ri_q < IDX_W'(count_i)) && outranks(best_v, child_rd_b_i, min_mode_i);

  assign tok_dn_o = tok_dn_q;
  assign tok_up_o = tok_up_q;

  // Read address select: one request at a time reaches a level
  always_comb begin
    ram_o.raddr_a = '0;
    ram_o.raddr_b = '0;
    if (fetch_i.valid && (fetch_i.level == lvl_i)) begin
      ram_o.raddr_a = fetch_i.pos;
    end else if (dn_req_i.valid) begin
      ram_o.raddr_a = POS_W'({dn_req_i.pos, 1'b0});
      ram_o.raddr_b = POS_W'({dn_req_i.pos, 1'b1});
    end else if (up_req_i.valid) begin
      ram_o.raddr_a = up_req_i.pos >> 1;
    end
  end

  // Sift step sequencer
  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    val_d       = val_q;
    tok_dn_d    = '0;
    tok_up_d    = '0;
    dn_req_o    = '0;
    up_req_o    = '0;
    ram_o.we    = 1'b0;
    ram_o.waddr = pos_q;
    ram_o.wdata = val_q;
    done_o      = 1'b0;
    case (state_q)
      C_IDLE: begin
        if (tok_dn_i.valid) begin
          pos_d = tok_dn_i.pos;
          val_d = tok_dn_i.value;
          if (li_in < IDX_W'(count_i)) begin
            dn_req_o = '{valid: 1'b1, pos: tok_dn_i.pos};
            state_d  = C_DN_WAIT;
          end else begin
            // leaf: element settles here
            ram_o.we    = 1'b1;
            ram_o.waddr = tok_dn_i.pos;
            ram_o.wdata = tok_dn_i.value;
            done_o      = 1'b1;
          end
        end else if (tok_up_i.valid) begin
          pos_d = tok_up_i.pos;
          val_d = tok_up_i.value;
          if (lvl_i == '0) begin
            ram_o.we    = 1'b1;
            ram_o.waddr = tok_up_i.pos;
            ram_o.wdata = tok_up_i.value;
            done_o      = 1'b1;
          end else begin
            up_req_o = '{valid: 1'b1, pos: tok_up_i.pos};
            state_d  = C_UP_WAIT;
          end
        end
      end
      C_DN_WAIT: begin
        ram_o.we = 1'b1;
        if (take_l || take_r) begin
          // winning child moves up, hole moves down
          ram_o.wdata    = take_r ? child_rd_b_i : child_rd_a_i;
          tok_dn_d.valid = 1'b1;
          tok_dn_d.pos   = POS_W'({pos_q, take_r});
          tok_dn_d.value = val_q;
        end else begin
          done_o = 1'b1;
        end
        state_d = C_IDLE;
      end
      C_UP_WAIT: begin
        ram_o.we = 1'b1;
        if (outranks(parent_rd_a_i, val_q, min_mode_i)) begin
          // parent moves down, hole moves up
          ram_o.wdata    = parent_rd_a_i;
          tok_up_d.valid = 1'b1;
          tok_up_d.pos   = pos_q >> 1;
          tok_up_d.value = val_q;
        end else begin
          done_o = 1'b1;
        end
        state_d = C_IDLE;
      end
      default: begin
        state_d = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= C_IDLE;
      tok_dn_q <= '0;
      tok_up_q <= '0;
    end else begin
      state_q  <= state_d;
      tok_dn_q <= tok_dn_d;
      tok_up_q <= tok_up_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    val_q <= val_d;
  end

endmodule

// ===== design/binary_heap_priority_queue_unit.sv =====
// Binary heap priority queue: one cell and one memory per heap level.
// Insert: the new element climbs from the first free slot; remove: the last element is
// read, placed at the root and sinks; both then re-read the root. Error cases and removing
// the last element go straight to the result.
// One word at a time: the next word is taken only after the result is loaded, and the
// result waits while the output is stalled; each level step is a read, then a compare.
// Reset clears the count and the min-mode bit; heap memories are not cleared.
module binary_heap_priority_queue_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bhpq_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bhpq_pkg::out_word_t out_word_o,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i
);
  import bhpq_pkg::*;

  ctl_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  data_t            top_q, top_d;
  logic             min_mode_q;
  status_e          status_q, status_d;
  data_t            removed_q, removed_d;
  logic [LVL_W-1:0] lvl_q, lvl_d;
  logic [POS_W-1:0] pos_q, pos_d;
  tok_t             inj_up_q, inj_up_d;
  logic [LVL_W-1:0] inj_lvl_q, inj_lvl_d;
  tok_t             inj_dn_q, inj_dn_d;
  logic             out_valid_q, out_valid_d;
  out_word_t        out_word_q, out_word_d;
  fetch_t           fetch_c;

  logic [CNT_W-1:0] j_ins;
  logic [LVL_W-1:0] lvl_ins, lvl_rem;
  logic [POS_W-1:0] pos_ins, pos_rem;

  tok_t             tok_dn  [NLVL];
  tok_t             tok_up  [NLVL];
  rdreq_t           dn_req  [NLVL];
  rdreq_t           up_req  [NLVL];
  ram_req_t         ram_req [NLVL];
  data_t            rd_a    [NLVL];
  data_t            rd_b    [NLVL];
  logic [NLVL-1:0]  done_vec;

  // Level and in-level position of the slot at one-based index j
  assign j_ins   = cnt_q + CNT_W'(1);
  assign lvl_ins = idx_level(j_ins);
  assign pos_ins = POS_W'(j_ins ^ (CNT_W'(1) << lvl_ins));
  assign lvl_rem = idx_level(cnt_q);
  assign pos_rem = POS_W'(cnt_q ^ (CNT_W'(1) << lvl_rem));

  // Chain of level cells, each with its own memory
  for (genvar k = 0; k < int'(NLVL); k++) begin : g_lvl
    localparam int unsigned LvlCap   = 1 << k;
    localparam int unsigned LvlDepth = (LvlCap < DEPTH - LvlCap + 1) ? LvlCap
                                                                     : DEPTH - LvlCap + 1;
    localparam int unsigned LvlAw    = (LvlDepth > 1) ? $clog2(LvlDepth) : 1;

    tok_t   tok_dn_in, tok_up_in;
    rdreq_t dn_req_in, up_req_in;
    data_t  child_a, child_b, parent_a;
    logic   inj_hit;

    assign inj_hit = inj_up_q.valid && (inj_lvl_q == LVL_W'(k));

    if (k == 0) begin : g_root
      assign tok_dn_in = inj_dn_q;
      assign dn_req_in = '0;
      assign parent_a  = '0;
    end else begin : g_inner_up
      assign tok_dn_in = tok_dn[k-1];
      assign dn_req_in = dn_req[k-1];
      assign parent_a  = rd_a[k-1];
    end

    if (k == int'(NLVL) - 1) begin : g_bottom
      assign up_req_in = '0;
      assign child_a   = '0;
      assign child_b   = '0;
      assign tok_up_in = inj_hit ? inj_up_q : '0;
    end else begin : g_inner_dn
      assign up_req_in = up_req[k+1];
      assign child_a   = rd_a[k+1];
      assign child_b   = rd_b[k+1];
      assign tok_up_in = inj_hit ? inj_up_q : tok_up[k+1];
    end

    bhpq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .lvl_i        (LVL_W'(k)),
      .min_mode_i   (min_mode_q),
      .count_i      (cnt_q),
      .fetch_i      (fetch_c),
      .tok_dn_i     (tok_dn_in),
      .tok_up_i     (tok_up_in),
      .tok_dn_o     (tok_dn[k]),
      .tok_up_o     (tok_up[k]),
      .dn_req_i     (dn_req_in),
      .up_req_i     (up_req_in),
      .dn_req_o     (dn_req[k]),
      .up_req_o     (up_req[k]),
      .child_rd_a_i (child_a),
      .child_rd_b_i (child_b),
      .parent_rd_a_i(parent_a),
      .ram_o        (ram_req[k]),
      .done_o       (done_vec[k])
    );

    bhpq_ram #(
      .AddrW(LvlAw),
      .DataW(DATA_W)
    ) u_ram (
      .clk_i    (clk_i),
      .we_i     (ram_req[k].we),
      .waddr_i  (ram_req[k].waddr[LvlAw-1:0]),
      .wdata_i  (ram_req[k].wdata),
      .raddr_a_i(ram_req[k].raddr_a[LvlAw-1:0]),
      .raddr_b_i(ram_req[k].raddr_b[LvlAw-1:0]),
      .rdata_a_o(rd_a[k]),
      .rdata_b_o(rd_b[k])
    );
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // Request sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    top_d       = top_q;
    status_d    = status_q;
    removed_d   = removed_q;
    lvl_d       = lvl_q;
    pos_d       = pos_q;
    inj_up_d    = '0;
    inj_lvl_d   = inj_lvl_q;
    inj_dn_d    = '0;
    fetch_c     = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_word_d  = out_word_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          status_d  = ST_OK;
          removed_d = '0;
          if (in_word_i.req_type == REQ_INSERT) begin
            if (cnt_q == CNT_W'(DEPTH)) begin
              status_d = ST_FULL;
              state_d  = S_DONE;
            end else begin
              // new element enters at the first free slot and climbs
              inj_up_d.valid = 1'b1;
              inj_up_d.pos   = pos_ins;
              inj_up_d.value = in_word_i.value;
              inj_lvl_d      = lvl_ins;
              cnt_d          = j_ins;
              state_d        = S_SIFT;
            end
          end else begin
            if (cnt_q == '0) begin
              status_d = ST_EMPTY;
              state_d  = S_DONE;
            end else begin
              removed_d = top_q;
              cnt_d     = cnt_q - CNT_W'(1);
              if (cnt_q == CNT_W'(1)) begin
                state_d = S_DONE;
              end else begin
                lvl_d   = lvl_rem;
                pos_d   = pos_rem;
                state_d = S_LAST_REQ;
              end
            end
          end
        end
      end
      S_LAST_REQ: begin
        fetch_c = '{valid: 1'b1, level: lvl_q, pos: pos_q};
        state_d = S_LAST_RD;
      end
      S_LAST_RD: begin
        // last element goes to the root and sinks
        inj_dn_d.valid = 1'b1;
        inj_dn_d.pos   = '0;
        inj_dn_d.value = rd_a[lvl_q];
        state_d        = S_SIFT;
      end
      S_SIFT: begin
        if (|done_vec) state_d = S_TOP_REQ;
      end
      S_TOP_REQ: begin
        fetch_c = '{valid: 1'b1, level: '0, pos: '0};
        state_d = S_TOP_RD;
      end
      S_TOP_RD: begin
        top_d   = rd_a[0];
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d              = 1'b1;
          out_word_d.status        = status_q;
          out_word_d.removed_value = removed_q;
          out_word_d.top_value     = (cnt_q != '0) ? top_q : '0;
          out_word_d.top_valid     = (cnt_q != '0);
          out_word_d.count         = cnt_q;
          state_d                  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      min_mode_q  <= 1'b0;
      inj_up_q    <= '0;
      inj_dn_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      inj_up_q    <= inj_up_d;
      inj_dn_q    <= inj_dn_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) min_mode_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q      <= top_d;
    status_q   <= status_d;
    removed_q  <= removed_d;
    lvl_q      <= lvl_d;
    pos_q      <= pos_d;
    inj_lvl_q  <= inj_lvl_d;
    out_word_q <= out_word_d;
  end

endmodule

// ===== design/bhpq_checker.sv =====
// Port-level checks for the heap priority queue, bound to the top level.
// Depends on bhpq_pkg and binary_heap_priority_queue_unit.
module bhpq_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input bhpq_pkg::in_word_t  in_word_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input bhpq_pkg::out_word_t out_word_o,
  input logic                cfg_we_i,
  input logic                cfg_wdata_i
);
  import bhpq_pkg::*;

  // Count stays within capacity
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.count <= CNT_W'(DEPTH)))
    else $error("count above capacity");

  // Top flag follows the count
  a_top_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.top_valid == (out_word_o.count != '0)))
    else $error("top_valid disagrees with count");

  // Remove from empty leaves an empty heap and no value
  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_word_o.status == ST_EMPTY)) |->
      ((out_word_o.count == '0) && (out_word_o.removed_value == '0)))
    else $error("empty status with elements or removed value");

  // Overflow only happens when full
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_word_o.status == ST_FULL)) |->
      (out_word_o.count == CNT_W'(DEPTH)))
    else $error("full status below capacity");

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_word_o)))
    else $error("result word changed while stalled");

endmodule

bind binary_heap_priority_queue_unit bhpq_checker u_bhpq_checker (.*);
